### rtl/grid_stencil_neighbor_lookup_top_defines.svh
// Assertion macros for the grid stencil neighbor lookup block.
// Used by rtl/grid_stencil_neighbor_lookup_top.sv; expects clk_i and rst_ni in scope.
`ifndef GRID_STENCIL_NEIGHBOR_LOOKUP_TOP_DEFINES_SVH
`define GRID_STENCIL_NEIGHBOR_LOOKUP_TOP_DEFINES_SVH

// Checked only while out of reset
`define GSNL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included
`define GSNL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### rtl/gsnl_pkg.sv
// Shared constants and types for the grid stencil neighbor lookup block.
// No dependencies; used by the top level.
`default_nettype none

package gsnl_pkg;

  localparam int GRID_DEPTH  = 256;
  localparam int ADDR_W      = $clog2(GRID_DEPTH);
  localparam int COUNT_W     = ADDR_W + 1;
  localparam int DATA_W      = 16;
  localparam int STENCIL_LEN = 4;
  localparam int CNT_W       = $clog2(STENCIL_LEN);

  // Command codes of an input beat
  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } gsnl_cmd_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SPAN  = 2'd1,
    ST_SMALL = 2'd2
  } gsnl_status_e;

  // Query sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_SCAN,
    S_STEN,
    S_DONE
  } gsnl_state_e;

endpackage

`default_nettype wire

### rtl/gsnl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module gsnl_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/grid_stencil_neighbor_lookup_top.sv
// A load beat is written in the cycle it is taken; busy stays low. A query with fewer
// than four grid entries gives its result beat in the cycle after start. Other queries
// read entry 0 and the last entry (S_FIRST, S_LAST) and stop there when outside the
// grid span, else scan the grid RAM's single read port downward and read the stencil.
// One query at a time; busy is high through the result beat, next beat in the cycle
// after it. Results cannot be stalled. Reset clears count_q and the sequencer only.
`default_nettype none
`include "grid_stencil_neighbor_lookup_top_defines.svh"

module grid_stencil_neighbor_lookup_top (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // command channel
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic                                 cmd_i,
  input  wire logic        [gsnl_pkg::ADDR_W-1:0]   entry_index_i,
  input  wire logic signed [gsnl_pkg::DATA_W-1:0]   entry_value_i,
  input  wire logic signed [gsnl_pkg::DATA_W-1:0]   query_point_i,
  // configuration channel
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic        [gsnl_pkg::COUNT_W-1:0]  cfg_data_i,
  // result channel
  output logic                                      done_o,
  output logic             [1:0]                    status_o,
  output logic             [gsnl_pkg::ADDR_W-1:0]   left_index_o,
  output logic signed      [gsnl_pkg::DATA_W-1:0]   left_value_o,
  output logic signed      [gsnl_pkg::DATA_W-1:0]   stencil_0_o,
  output logic signed      [gsnl_pkg::DATA_W-1:0]   stencil_1_o,
  output logic signed      [gsnl_pkg::DATA_W-1:0]   stencil_2_o,
  output logic signed      [gsnl_pkg::DATA_W-1:0]   stencil_3_o
);

  localparam int AW = gsnl_pkg::ADDR_W;
  localparam int CW = gsnl_pkg::COUNT_W;
  localparam int DW = gsnl_pkg::DATA_W;
  localparam int KW = gsnl_pkg::CNT_W;
  localparam int SW = CW + 1;
  localparam logic [CW-1:0] DEPTH_CNT = CW'(gsnl_pkg::GRID_DEPTH);
  localparam logic [CW-1:0] MIN_CNT   = CW'(gsnl_pkg::STENCIL_LEN);
  localparam logic [KW-1:0] LAST_TAP  = KW'(gsnl_pkg::STENCIL_LEN - 1);

  gsnl_pkg::gsnl_state_e  state_q, state_d;
  gsnl_pkg::gsnl_status_e status_q, status_d;

  logic [CW-1:0]        count_q;
  logic [CW-1:0]        n_q, n_d;
  logic signed [DW-1:0] pt_q, pt_d;
  logic [AW-1:0]        idx_q, idx_d;
  logic [KW-1:0]        cnt_q, cnt_d;
  logic                 span_q, span_d;
  logic [AW-1:0]        left_idx_q, left_idx_d;
  logic signed [DW-1:0] left_val_q, left_val_d;
  logic signed [DW-1:0] sten_q [gsnl_pkg::STENCIL_LEN];
  logic signed [DW-1:0] sten_d [gsnl_pkg::STENCIL_LEN];

  logic                 accept;
  logic                 ram_we;
  logic [AW-1:0]        raddr;
  logic [DW-1:0]        rdata;
  logic signed [DW-1:0] rval;
  logic [CW-1:0]        n_act;
  logic signed [SW-1:0] left_s;
  logic signed [SW-1:0] s_raw;
  logic signed [SW-1:0] s_hi;
  logic signed [SW-1:0] s_clamp;

  // Handshakes
  assign busy        = (state_q != gsnl_pkg::S_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;
  assign ram_we      = accept && (cmd_i == gsnl_pkg::CMD_LOAD);
  assign n_act       = (count_q > DEPTH_CNT) ? DEPTH_CNT : count_q;
  assign rval        = $signed(rdata);

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      count_q <= cfg_data_i;
    end
  end

  // Grid store
  gsnl_ram #(
    .DEPTH (gsnl_pkg::GRID_DEPTH),
    .WIDTH (DW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (entry_index_i),
    .wdata_i (entry_value_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Stencil start from the found neighbor, clamped to 0 .. n-4
  always_comb begin
    left_s = $signed({{(SW - AW){1'b0}}, idx_q});
    s_hi   = $signed({1'b0, n_q}) - $signed({1'b0, MIN_CNT});
    if (rval < 0) begin
      s_raw = (idx_q == '0) ? '0 : left_s - SW'(1);
    end else if ({1'b0, idx_q} + CW'(1) >= n_q) begin
      s_raw = left_s - SW'(1);
    end else begin
      s_raw = left_s - SW'(2);
    end
    if (s_raw < 0) begin
      s_clamp = '0;
    end else if (s_raw > s_hi) begin
      s_clamp = s_hi;
    end else begin
      s_clamp = s_raw;
    end
  end

  // Sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gsnl_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    status_q   <= status_d;
    n_q        <= n_d;
    pt_q       <= pt_d;
    idx_q      <= idx_d;
    cnt_q      <= cnt_d;
    span_q     <= span_d;
    left_idx_q <= left_idx_d;
    left_val_q <= left_val_d;
    sten_q     <= sten_d;
  end

  // Next state, read address and datapath updates
  always_comb begin
    state_d    = state_q;
    status_d   = status_q;
    n_d        = n_q;
    pt_d       = pt_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    span_d     = span_q;
    left_idx_d = left_idx_q;
    left_val_d = left_val_q;
    sten_d     = sten_q;
    raddr      = '0;
    unique case (state_q)
      gsnl_pkg::S_IDLE: begin
        if (accept && (cmd_i == gsnl_pkg::CMD_QUERY)) begin
          n_d        = n_act;
          pt_d       = query_point_i;
          left_idx_d = '0;
          left_val_d = '0;
          for (int k = 0; k < gsnl_pkg::STENCIL_LEN; k++) begin
            sten_d[k] = '0;
          end
          if (n_act < MIN_CNT) begin
            status_d = gsnl_pkg::ST_SMALL;
            state_d  = gsnl_pkg::S_DONE;
          end else begin
            status_d = gsnl_pkg::ST_OK;
            state_d  = gsnl_pkg::S_FIRST;
          end
        end
      end
      gsnl_pkg::S_FIRST: begin
        // entry 0 on the read port; fetch the last entry next
        span_d  = (pt_q < rval);
        raddr   = AW'(n_q - CW'(1));
        state_d = gsnl_pkg::S_LAST;
      end
      gsnl_pkg::S_LAST: begin
        if (span_q || (pt_q >= rval)) begin
          status_d = gsnl_pkg::ST_SPAN;
          state_d  = gsnl_pkg::S_DONE;
        end else begin
          idx_d   = AW'(n_q - CW'(2));
          raddr   = AW'(n_q - CW'(2));
          state_d = gsnl_pkg::S_SCAN;
        end
      end
      gsnl_pkg::S_SCAN: begin
        // downward scan; entry 0 is known to qualify
        if (rval <= pt_q) begin
          left_idx_d = idx_q;
          left_val_d = rval;
          idx_d      = AW'(s_clamp);
          raddr      = AW'(s_clamp);
          cnt_d      = '0;
          state_d    = gsnl_pkg::S_STEN;
        end else begin
          idx_d = idx_q - AW'(1);
          raddr = idx_q - AW'(1);
        end
      end
      gsnl_pkg::S_STEN: begin
        sten_d[cnt_q] = rval;
        raddr         = idx_q + AW'(cnt_q) + AW'(1);
        cnt_d         = cnt_q + KW'(1);
        if (cnt_q == LAST_TAP) begin
          state_d = gsnl_pkg::S_DONE;
        end
      end
      gsnl_pkg::S_DONE: begin
        state_d = gsnl_pkg::S_IDLE;
      end
      default: begin
        state_d = gsnl_pkg::S_IDLE;
      end
    endcase
  end

  // Result beat
  assign done_o       = (state_q == gsnl_pkg::S_DONE);
  assign status_o     = status_q;
  assign left_index_o = left_idx_q;
  assign left_value_o = left_val_q;
  assign stencil_0_o  = sten_q[0];
  assign stencil_1_o  = sten_q[1];
  assign stencil_2_o  = sten_q[2];
  assign stencil_3_o  = sten_q[3];

  // Assertions
  `GSNL_ASSERT_ALWAYS(a_no_beat_in_reset, !rst_ni |-> !done_o, "result beat during reset")
  `GSNL_ASSERT(a_single_beat, done_o |=> !done_o, "result beat lasted more than one cycle")
  `GSNL_ASSERT(a_scan_bound, (state_q == gsnl_pkg::S_SCAN) |-> ({1'b0, idx_q} + CW'(2) <= n_q), "scan index beyond grid")
  `GSNL_ASSERT(a_sten_bound, (done_o && (status_q == gsnl_pkg::ST_OK)) |-> ({1'b0, idx_q} + MIN_CNT <= n_q), "stencil window past grid end")
  `GSNL_ASSERT(a_left_in_grid, (done_o && (status_q == gsnl_pkg::ST_OK)) |-> ({1'b0, left_idx_q} + CW'(2) <= n_q), "neighbor index outside grid span")

endmodule

`default_nettype wire
